// File: rtl/nau_pkg.sv
// ----------------------------------------------------------------------------
// nau_pkg
// Shared sizes, codes, control word layout and microcode program of the
// accumulator update block.
// ----------------------------------------------------------------------------
`default_nettype none

package nau_pkg;

  // Sizes
  localparam int ACC_DIM      = 256;
  localparam int NUM_FEATURES = 1024;
  localparam int STACK_DEPTH  = 8;

  localparam int DATA_W  = 16;
  localparam int KIND_W  = 3;
  localparam int FEAT_W  = 10;
  localparam int DIMF_W  = 8;
  localparam int STAT_W  = 2;

  localparam int IDX_W   = (ACC_DIM > 1) ? $clog2(ACC_DIM) : 1;
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int SLOT_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int WADDR_W = $clog2(ACC_DIM * NUM_FEATURES);
  localparam int SADDR_W = (STACK_DEPTH * ACC_DIM > 1) ? $clog2(STACK_DEPTH * ACC_DIM) : 1;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  // Item kinds
  localparam logic [KIND_W-1:0] K_WR_WEIGHT = 3'd0;
  localparam logic [KIND_W-1:0] K_WR_BIAS   = 3'd1;
  localparam logic [KIND_W-1:0] K_INIT      = 3'd2;
  localparam logic [KIND_W-1:0] K_PUSH      = 3'd3;
  localparam logic [KIND_W-1:0] K_ADD       = 3'd4;
  localparam logic [KIND_W-1:0] K_SUB       = 3'd5;
  localparam logic [KIND_W-1:0] K_POP       = 3'd6;
  localparam logic [KIND_W-1:0] K_READ      = 3'd7;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVER  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDER = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  // Write modes of the element pipeline
  localparam logic [2:0] M_NONE = 3'd0;
  localparam logic [2:0] M_INIT = 3'd1;
  localparam logic [2:0] M_ADD  = 3'd2;
  localparam logic [2:0] M_SUB  = 3'd3;
  localparam logic [2:0] M_PUSH = 3'd4;
  localparam logic [2:0] M_POP  = 3'd5;

  // Microcode step addresses
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] S_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] S_WRW   = 4'd1;
  localparam logic [PC_W-1:0] S_WRB   = 4'd2;
  localparam logic [PC_W-1:0] S_RD    = 4'd3;
  localparam logic [PC_W-1:0] S_RDOUT = 4'd4;
  localparam logic [PC_W-1:0] S_INIT  = 4'd5;
  localparam logic [PC_W-1:0] S_ADD   = 4'd6;
  localparam logic [PC_W-1:0] S_SUB   = 4'd7;
  localparam logic [PC_W-1:0] S_PUSH  = 4'd8;
  localparam logic [PC_W-1:0] S_POP   = 4'd9;
  localparam logic [PC_W-1:0] S_DRAIN = 4'd10;
  localparam logic [PC_W-1:0] S_NOP   = 4'd11;

  typedef struct packed {
    logic            dispatch;  // wait for an item, then jump to its entry
    logic            rd;        // issue element reads at the index
    logic [2:0]      mode;      // write applied when the read data returns
    logic            wr_w;      // write one weight
    logic            wr_b;      // write one bias
    logic            rd_res;    // take the accumulator element as result
    logic            done;      // load the result register
    logic            loop;      // repeat until the last element
    logic [PC_W-1:0] nxt;
  } ctl_t;

  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t c;
    c = '0;
    c.nxt = S_IDLE;
    case (pc)
      S_IDLE:  begin c.dispatch = 1'b1; end
      S_WRW:   begin c.wr_w = 1'b1; c.done = 1'b1; end
      S_WRB:   begin c.wr_b = 1'b1; c.done = 1'b1; end
      S_RD:    begin c.rd = 1'b1; c.nxt = S_RDOUT; end
      S_RDOUT: begin c.rd_res = 1'b1; c.done = 1'b1; end
      S_INIT:  begin c.rd = 1'b1; c.mode = M_INIT; c.loop = 1'b1; c.nxt = S_DRAIN; end
      S_ADD:   begin c.rd = 1'b1; c.mode = M_ADD;  c.loop = 1'b1; c.nxt = S_DRAIN; end
      S_SUB:   begin c.rd = 1'b1; c.mode = M_SUB;  c.loop = 1'b1; c.nxt = S_DRAIN; end
      S_PUSH:  begin c.rd = 1'b1; c.mode = M_PUSH; c.loop = 1'b1; c.nxt = S_DRAIN; end
      S_POP:   begin c.rd = 1'b1; c.mode = M_POP;  c.loop = 1'b1; c.nxt = S_DRAIN; end
      S_DRAIN: begin c.done = 1'b1; end
      S_NOP:   begin c.done = 1'b1; end
      default: begin c.dispatch = 1'b1; end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/nau_ram.sv
// ----------------------------------------------------------------------------
// nau_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module nau_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/nau_seq.sv
// ----------------------------------------------------------------------------
// nau_seq
// Microcode sequencer: step counter over the control word table, with
// dispatch on a new item and a loop jump on the element index.
// ----------------------------------------------------------------------------
`default_nettype none

module nau_seq import nau_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [PC_W-1:0] entry,
  input  wire logic            last,
  output ctl_t                 ctl
);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;

  assign ctl = ucode(pc_r);

  always_comb begin
    if (ctl.dispatch) begin
      pc_nxt = start ? entry : pc_r;
    end else if (ctl.loop && !last) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = ctl.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/nnue_accumulator_update.sv
// ----------------------------------------------------------------------------
// nnue_accumulator_update
// Incremental first-layer accumulator with weight and bias stores and a
// snapshot stack, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Each input transfer yields exactly one result transfer. Weight and bias
// writes finish in their write step, a read in its read and output steps; an
// item that is rejected (range, overflow, underflow) or a pop of an invalid
// snapshot ends in the no-op step. Init, add, remove, push and a restoring pop
// walk the whole vector one element per cycle through the element pipeline of
// the accumulator RAM, then end in the drain step. One item is in work at a
// time; a new item is taken as soon as the sequencer is back at its idle step
// and the result register is free or being emptied. The accumulator keeps
// one valid bit per element, cleared by reset, so that an element never
// written reads as zero without any clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module nnue_accumulator_update import nau_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata: feature_index[9:0], dim_index[17:10], data_value[33:18], zero pad
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: kind[2:0]
  input  wire logic [KIND_W-1:0]     in_tuser,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // out_tdata: read_value[15:0], acc_valid[16], status[18:17], zero pad
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready
);

  // Field unpacking
  logic [KIND_W-1:0] in_kind;
  logic [FEAT_W-1:0] in_feat;
  logic [DIMF_W-1:0] in_dim;
  logic [DATA_W-1:0] in_data;

  assign in_kind = in_tuser;
  assign in_feat = in_tdata[FEAT_W-1:0];
  assign in_dim  = in_tdata[FEAT_W+DIMF_W-1:FEAT_W];
  assign in_data = in_tdata[FEAT_W+DIMF_W+DATA_W-1:FEAT_W+DIMF_W];

  // Sequencer
  ctl_t            ctl;
  logic            accept;
  logic [PC_W-1:0] entry;
  logic [IDX_W-1:0] idx_r;
  logic            last;

  assign last = (idx_r == IDX_W'(ACC_DIM - 1));

  nau_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .entry (entry),
    .last  (last),
    .ctl   (ctl)
  );

  // Take a new item only at the idle step with the result register free or being emptied
  logic out_valid_r;
  assign in_tready = ctl.dispatch && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  // Stack and flag state
  logic [DEPTH_W-1:0] depth_r;
  logic               acc_valid_r;
  logic [STACK_DEPTH-1:0] vstack_r;
  logic [DEPTH_W-1:0] slot;
  logic               feat_ok;
  logic               dim_ok;
  logic               stack_full;
  logic               stack_empty;
  logic [STAT_W-1:0]  status_nxt;

  assign feat_ok     = (32'(in_feat) < 32'(NUM_FEATURES));
  assign dim_ok      = (32'(in_dim) < 32'(ACC_DIM));
  assign stack_full  = (depth_r == DEPTH_W'(STACK_DEPTH));
  assign stack_empty = (depth_r == '0);
  // Pop uses the top slot, push the next free one
  assign slot = (in_kind == K_POP) ? depth_r - DEPTH_W'(1) : depth_r;

  // Decode: pick the microcode entry and the status of the item
  always_comb begin
    entry      = S_NOP;
    status_nxt = ST_OK;
    case (in_kind)
      K_WR_WEIGHT: begin
        if (feat_ok && dim_ok) entry = S_WRW;
        else status_nxt = ST_RANGE;
      end
      K_WR_BIAS: begin
        if (dim_ok) entry = S_WRB;
        else status_nxt = ST_RANGE;
      end
      K_INIT: begin
        entry = S_INIT;
      end
      K_PUSH: begin
        if (!stack_full) entry = S_PUSH;
        else status_nxt = ST_OVER;
      end
      K_ADD: begin
        if (feat_ok) entry = S_ADD;
        else status_nxt = ST_RANGE;
      end
      K_SUB: begin
        if (feat_ok) entry = S_SUB;
        else status_nxt = ST_RANGE;
      end
      K_POP: begin
        // An invalid snapshot leaves the vector alone: no restore walk
        if (stack_empty) status_nxt = ST_UNDER;
        else if (vstack_r[slot[SLOT_W-1:0]]) entry = S_POP;
      end
      K_READ: begin
        if (dim_ok) entry = S_RD;
        else status_nxt = ST_RANGE;
      end
      default: begin
        entry = S_NOP;
      end
    endcase
  end

  // Flag, depth and valid stack update at acceptance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      acc_valid_r <= 1'b0;
    end else if (accept) begin
      if (in_kind == K_INIT) begin
        acc_valid_r <= 1'b1;
      end
      if (in_kind == K_PUSH && !stack_full) begin
        depth_r <= depth_r + DEPTH_W'(1);
      end
      if (in_kind == K_POP && !stack_empty) begin
        depth_r     <= depth_r - DEPTH_W'(1);
        acc_valid_r <= vstack_r[slot[SLOT_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_kind == K_PUSH && !stack_full) begin
      vstack_r[slot[SLOT_W-1:0]] <= acc_valid_r;
    end
  end

  // Item registers: index, bases, data, status
  logic [WADDR_W-1:0] w_base_r;
  logic [SADDR_W-1:0] s_base_r;
  logic [DATA_W-1:0]  data_r;
  logic [STAT_W-1:0]  status_r;
  logic [IDX_W-1:0]   idx_nxt;

  always_comb begin
    idx_nxt = idx_r;
    if (accept) begin
      if (in_kind == K_WR_WEIGHT || in_kind == K_WR_BIAS || in_kind == K_READ) begin
        idx_nxt = IDX_W'(32'(in_dim));
      end else begin
        idx_nxt = '0;
      end
    end else if (ctl.loop) begin
      idx_nxt = last ? '0 : idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (accept) begin
      w_base_r <= WADDR_W'(32'(in_feat) * ACC_DIM);
      s_base_r <= SADDR_W'(32'(slot) * ACC_DIM);
      data_r   <= in_data;
      status_r <= status_nxt;
    end
  end

  // Element pipeline: read at idx_r now, write the same element next cycle
  logic             pend_r;
  logic [2:0]       pend_mode_r;
  logic [IDX_W-1:0] pend_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= ctl.rd;
    end
    pend_mode_r <= ctl.mode;
    pend_idx_r  <= idx_r;
  end

  // Memories
  logic [DATA_W-1:0]  acc_q;
  logic [DATA_W-1:0]  bias_q;
  logic [DATA_W-1:0]  w_q;
  logic [DATA_W-1:0]  snap_q;
  logic [DATA_W-1:0]  acc_m;
  logic [DATA_W-1:0]  acc_wdata;
  logic               acc_we;
  logic               snap_we;
  logic [ACC_DIM-1:0] acc_vld_r;
  logic               rd_vld_r;

  // Unwritten accumulator elements read as zero
  assign acc_m = rd_vld_r ? acc_q : '0;

  always_comb begin
    acc_we    = 1'b0;
    snap_we   = 1'b0;
    acc_wdata = acc_m;
    if (pend_r) begin
      case (pend_mode_r)
        M_INIT: begin acc_we = 1'b1; acc_wdata = bias_q; end
        M_ADD:  begin acc_we = 1'b1; acc_wdata = acc_m + w_q; end
        M_SUB:  begin acc_we = 1'b1; acc_wdata = acc_m - w_q; end
        M_POP:  begin acc_we = 1'b1; acc_wdata = snap_q; end
        M_PUSH: begin snap_we = 1'b1; end
        default: begin acc_we = 1'b0; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= '0;
    end else if (acc_we) begin
      acc_vld_r[pend_idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_vld_r <= acc_vld_r[idx_r];
  end

  nau_ram #(.WIDTH(DATA_W), .DEPTH(ACC_DIM)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (pend_idx_r),
    .wdata (acc_wdata),
    .raddr (idx_r),
    .rdata (acc_q)
  );

  nau_ram #(.WIDTH(DATA_W), .DEPTH(ACC_DIM)) u_bias_ram (
    .clk   (clk),
    .we    (ctl.wr_b),
    .waddr (idx_r),
    .wdata (data_r),
    .raddr (idx_r),
    .rdata (bias_q)
  );

  nau_ram #(.WIDTH(DATA_W), .DEPTH(ACC_DIM * NUM_FEATURES)) u_weight_ram (
    .clk   (clk),
    .we    (ctl.wr_w),
    .waddr (w_base_r + WADDR_W'(idx_r)),
    .wdata (data_r),
    .raddr (w_base_r + WADDR_W'(idx_r)),
    .rdata (w_q)
  );

  nau_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH * ACC_DIM)) u_snap_ram (
    .clk   (clk),
    .we    (snap_we),
    .waddr (s_base_r + SADDR_W'(pend_idx_r)),
    .wdata (acc_m),
    .raddr (s_base_r + SADDR_W'(idx_r)),
    .rdata (snap_q)
  );

  // Result register: hold until the transfer completes
  logic [DATA_W-1:0] rv_r;
  logic              res_valid_r;
  logic [STAT_W-1:0] res_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.done) begin
      rv_r         <= ctl.rd_res ? acc_m : '0;
      res_valid_r  <= acc_valid_r;
      res_status_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - DATA_W - 1 - STAT_W){1'b0}},
                       res_status_r, res_valid_r, rv_r};

`ifndef SYNTH
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(depth_r) <= 32'(STACK_DEPTH))
    else $error("stack depth beyond its limit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.done && out_valid_r) |-> out_tready)
    else $error("result register overwritten before transfer");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.done))
    else $error("result appeared without a finished item");

  a_no_accept_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (!ctl.rd && !pend_r))
    else $error("item accepted while the element pipeline is busy");
`endif

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of the accumulator update block. Every accepted item is
// run through a shadow copy of the weight, bias, accumulator and snapshot
// state; each result transfer is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_top import nau_pkg::*; ();

  localparam int RANDOM_ITEMS   = 1025;
  localparam int TAIL_ITEMS     = 120;   // final stretch with no idling at all
  localparam int HOLD_AT        = 200;   // input transfers before the long hold-off
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int FEAT_A         = NUM_FEATURES - 1;

  // Expected content of one result transfer
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              valid;
    logic [DATA_W-1:0] value;
  } acc_result_t;

  // One write of the table-loading sequence
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [FEAT_W-1:0] feat;
    logic [DIMF_W-1:0] dim;
  } load_write_t;

  // --------------------------------------------------------------------------
  // Shadow state of the block plus the queue of predicted results
  // --------------------------------------------------------------------------
  class acc_scoreboard;
    bit [DATA_W-1:0] weights     [ACC_DIM*NUM_FEATURES];
    bit              weight_seen [ACC_DIM*NUM_FEATURES];
    int unsigned     column_fill [NUM_FEATURES];
    bit [DATA_W-1:0] biases    [ACC_DIM];
    bit              bias_seen [ACC_DIM];
    int unsigned     bias_fill;
    bit [DATA_W-1:0] acc [ACC_DIM];
    bit              acc_live;
    bit [DATA_W-1:0] snap_vec  [STACK_DEPTH][ACC_DIM];
    bit              snap_live [STACK_DEPTH];
    int unsigned     depth;
    acc_result_t     pending_q [$];
    int unsigned     mismatches;
    int unsigned     checked;

    // Apply one accepted item to the shadow state and queue its result.
    function void note_item(input logic [KIND_W-1:0] kind, input logic [FEAT_W-1:0] feat,
                            input logic [DIMF_W-1:0] dim, input logic [DATA_W-1:0] data);
      acc_result_t r;
      int unsigned slot;
      bit          feat_ok;
      bit          dim_ok;
      r       = '0;
      r.status = ST_OK;
      feat_ok = int'(feat) < NUM_FEATURES;
      dim_ok  = int'(dim) < ACC_DIM;
      slot    = int'(feat) * ACC_DIM + int'(dim);
      case (kind)
        K_WR_WEIGHT: begin
          if (feat_ok && dim_ok) begin
            if (!weight_seen[slot]) begin
              weight_seen[slot] = 1'b1;
              column_fill[feat]++;
            end
            weights[slot] = data;
          end else begin
            r.status = ST_RANGE;
          end
        end
        K_WR_BIAS: begin
          if (dim_ok) begin
            if (!bias_seen[dim]) begin
              bias_seen[dim] = 1'b1;
              bias_fill++;
            end
            biases[dim] = data;
          end else begin
            r.status = ST_RANGE;
          end
        end
        K_INIT: begin
          for (int i = 0; i < ACC_DIM; i++) acc[i] = biases[i];
          acc_live = 1'b1;
        end
        K_PUSH: begin
          if (depth >= STACK_DEPTH) begin
            r.status = ST_OVER;
          end else begin
            for (int i = 0; i < ACC_DIM; i++) snap_vec[depth][i] = acc[i];
            snap_live[depth] = acc_live;
            depth++;
          end
        end
        K_ADD, K_SUB: begin
          if (feat_ok) begin
            for (int i = 0; i < ACC_DIM; i++) begin
              if (kind == K_ADD) acc[i] = acc[i] + weights[int'(feat) * ACC_DIM + i];
              else               acc[i] = acc[i] - weights[int'(feat) * ACC_DIM + i];
            end
          end else begin
            r.status = ST_RANGE;
          end
        end
        K_POP: begin
          if (depth == 0) begin
            r.status = ST_UNDER;
          end else begin
            depth--;
            // an invalid snapshot only drops the valid mark
            if (snap_live[depth]) begin
              for (int i = 0; i < ACC_DIM; i++) acc[i] = snap_vec[depth][i];
              acc_live = 1'b1;
            end else begin
              acc_live = 1'b0;
            end
          end
        end
        default: begin
          if (dim_ok) r.value = acc[dim];
          else        r.status = ST_RANGE;
        end
      endcase
      r.valid = acc_live;
      pending_q.push_back(r);
    endfunction

    task report(input string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_result(input logic [OUT_DATA_W-1:0] word);
      acc_result_t e;
      checked++;
      if (pending_q.size() == 0) begin
        report($sformatf("result %0d (%h) with nothing outstanding", checked, word));
        return;
      end
      e = pending_q.pop_front();
      if (word[15:0] !== e.value)
        report($sformatf("result %0d read_value %h, want %h", checked, word[15:0], e.value));
      if (word[16] !== e.valid)
        report($sformatf("result %0d acc_valid %b, want %b", checked, word[16], e.valid));
      if (word[18:17] !== e.status)
        report($sformatf("result %0d status %0d, want %0d", checked, word[18:17], e.status));
      if (word[OUT_DATA_W-1:19] !== '0)
        report($sformatf("result %0d pad bits %h not zero", checked, word[OUT_DATA_W-1:19]));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT and shared run state
  // --------------------------------------------------------------------------
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [KIND_W-1:0]     in_tuser   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;

  acc_scoreboard sb;
  int unsigned   in_count;
  int unsigned   out_count;
  int unsigned   quiet_cycles;
  bit            calm_tail;
  bit            hold_active;
  bit            hold_done;

  initial begin
    forever #6 clk = ~clk;
  end

  nnue_accumulator_update dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  // Idling is allowed in three of every four windows, so some stretches
  // run back to back.
  function automatic bit idle_window(input int unsigned count);
    return ((count / 48) % 4) != 3;
  endfunction

  // Bias the data toward the corners of the signed range.
  function automatic logic [DATA_W-1:0] data_pattern();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      3:       return 16'h0001;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Offer one item, hold it until the transfer, then log it.
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [FEAT_W-1:0] feat,
                           input logic [DIMF_W-1:0] dim, input logic [DATA_W-1:0] data);
    if (!calm_tail && !hold_active && idle_window(in_count) && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tdata  <= {{(IN_DATA_W-FEAT_W-DIMF_W-DATA_W){1'b0}}, data, dim, feat};
    in_tuser  <= kind;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_item(kind, feat, dim, data);
    in_count++;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random backpressure plus one long hold-off so the block
  // fills up and drops in_tready while items keep coming.
  // --------------------------------------------------------------------------
  initial begin : receiver
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!hold_done && in_count >= HOLD_AT) begin
        hold_active = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
        hold_done   = 1'b1;
      end else if (!calm_tail && idle_window(out_count) && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata);
      out_count++;
    end
  end

  // Abort when neither side has moved a transfer for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    load_write_t       load_q [$];
    load_write_t       w;
    int                order [ACC_DIM];
    int                ready_q [$];
    int                j;
    int                tmp;
    int unsigned       pick;
    logic [FEAT_W-1:0] feat_b;
    logic [KIND_W-1:0] kind;
    logic [FEAT_W-1:0] feat;
    logic [DIMF_W-1:0] dim;
    logic [DATA_W-1:0] data;

    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reads of the cleared vector at both ends, empty-stack pop,
    // corner weight and bias writes, overflow of the stack with invalid
    // snapshots, then unwind them (each pop only clears the valid mark).
    send_item(K_READ, '0, '0, '0);
    send_item(K_READ, '1, DIMF_W'(ACC_DIM - 1), '1);
    send_item(K_POP, '1, '1, '1);
    send_item(K_WR_WEIGHT, '0, '0, 16'h8000);
    send_item(K_WR_WEIGHT, FEAT_W'(NUM_FEATURES - 1), DIMF_W'(ACC_DIM - 1), 16'h7fff);
    send_item(K_WR_BIAS, '1, '0, 16'h8000);
    send_item(K_WR_BIAS, '0, DIMF_W'(ACC_DIM - 1), 16'h7fff);
    for (int i = 0; i <= STACK_DEPTH; i++) send_item(K_PUSH, FEAT_W'($urandom), '0, '0);
    send_item(K_READ, '0, DIMF_W'(ACC_DIM / 2), '0);
    for (int i = 0; i < STACK_DEPTH; i++) send_item(K_POP, '0, DIMF_W'($urandom), '1);

    // Loading sequence: every bias, then the full columns of two features,
    // each in a shuffled element order. Init and add/remove stay off until
    // the tables they read are complete.
    feat_b = FEAT_W'($urandom_range(1, NUM_FEATURES - 2));
    for (int g = 0; g < 3; g++) begin
      for (int i = 0; i < ACC_DIM; i++) order[i] = i;
      for (int i = ACC_DIM - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      for (int i = 0; i < ACC_DIM; i++) begin
        w.kind = (g == 0) ? K_WR_BIAS : K_WR_WEIGHT;
        w.feat = (g == 0) ? FEAT_W'($urandom) : ((g == 1) ? FEAT_W'(FEAT_A) : feat_b);
        w.dim  = DIMF_W'(order[i]);
        load_q.push_back(w);
      end
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm_tail = (n >= RANDOM_ITEMS - TAIL_ITEMS);
      if (load_q.size() != 0 && $urandom_range(0, 99) < 85) begin
        w = load_q.pop_front();
        send_item(w.kind, w.feat, w.dim, data_pattern());
      end else begin
        ready_q.delete();
        if (sb.column_fill[FEAT_A] == ACC_DIM) ready_q.push_back(FEAT_A);
        if (sb.column_fill[feat_b] == ACC_DIM) ready_q.push_back(int'(feat_b));
        pick = $urandom_range(0, 99);
        feat = FEAT_W'($urandom);
        dim  = DIMF_W'($urandom);
        data = DATA_W'($urandom);
        // fall through to the next kind when a table is not loaded yet
        if (pick < 14 && sb.bias_fill == ACC_DIM) begin
          kind = K_INIT;
        end else if (pick < 36 && ready_q.size() != 0) begin
          kind = pick[0] ? K_ADD : K_SUB;
          feat = FEAT_W'(ready_q[$urandom_range(0, ready_q.size() - 1)]);
        end else if (pick < 48) begin
          kind = K_PUSH;
        end else if (pick < 60) begin
          kind = K_POP;
        end else if (pick < 86) begin
          kind = K_READ;
        end else if (pick < 94) begin
          kind = K_WR_WEIGHT;
          data = data_pattern();
        end else begin
          kind = K_WR_BIAS;
          data = data_pattern();
        end
        send_item(kind, feat, dim, data);
      end
    end
    in_tvalid <= 1'b0;

    // Drain: wait for every outstanding result, then a short tail to catch
    // any stray transfer.
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
